/* design/adc_listmode_word_unpacker_defines.svh */
// Assertion macros used by almwu_checker.sv.
`ifndef ADC_LISTMODE_WORD_UNPACKER_DEFINES_SVH
`define ADC_LISTMODE_WORD_UNPACKER_DEFINES_SVH

// Checked only while out of reset.
`define ALMWU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define ALMWU_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/almwu_pkg.sv */
`timescale 1ns / 1ps

package almwu_pkg;

  localparam logic [3:0] KIND_BLOCK_HDR  = 4'd0;
  localparam logic [3:0] KIND_MODULE_HDR = 4'd1;
  localparam logic [3:0] KIND_HIT        = 4'd2;
  localparam logic [3:0] KIND_TDIFF      = 4'd3;
  localparam logic [3:0] KIND_EXT_TS     = 4'd4;
  localparam logic [3:0] KIND_EVENT_TS   = 4'd5;
  localparam logic [3:0] KIND_FILLER     = 4'd6;
  localparam logic [3:0] KIND_HIT_RANGE  = 4'd7;
  localparam logic [3:0] KIND_IGNORED    = 4'd8;
  localparam logic [3:0] KIND_BIN_READ   = 4'd9;

  typedef struct packed {
    logic [3:0]  kind;
    logic [3:0]  bus;
    logic [11:0] channel;
    logic [15:0] value;
    logic [9:0]  hit_count;
    logic [5:0]  time_diff_count;
    logic [15:0] ext_stamp;
    logic [29:0] event_stamp;
    logic [31:0] broken;
    logic        bin_upd;   // increment the addressed bin
    logic        bin_rd;    // report the addressed bin as is
  } item_t;

endpackage

/* design/adc_listmode_word_unpacker.sv */
`timescale 1ns / 1ps
// Readout word unpacker with per-bus, per-channel amplitude histogram.
// Input channel: in_valid / in_stall carry one item, either a 32-bit
// readout word (in_op = 0) or a histogram bin query (in_op = 1).
// Result channel: out_valid / out_stall carry exactly one result per item,
// in order, with the decoded kind, fields, event counters after the item
// and the bin count (after the increment for a hit, as stored for a query).
// Each accepted item passes the read stage and then the output register.
// Throughput: one item per cycle while in_stall is low; the histogram update is
// a read in the accept cycle and a write when the item leaves the read stage,
// with the write forwarded to an item to the same bin that follows directly.
// Reset: framing returns to expecting a block header and all counters
// clear; the histogram memory, 2^ADDR_W bins (4194304 at the default
// sizes), is then swept to zero, one bin per cycle, while in_stall
// stays high.
// Stall: when out_stall holds the output register, one more item may be
// accepted into the read stage; after that in_stall rises until the
// result is taken.
module adc_listmode_word_unpacker #(
  parameter int BUSES     = 16,
  parameter int CHANNELS  = 64,
  parameter int BINS      = 4096,
  parameter int MAX_HITS  = 1023,
  parameter int MAX_TDIFF = 47
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_op,
  input  logic [31:0] in_word,
  input  logic [3:0]  in_query_bus,
  input  logic [5:0]  in_query_channel,
  input  logic [11:0] in_query_bin,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_kind,
  output logic [3:0]  out_bus,
  output logic [11:0] out_channel,
  output logic [15:0] out_value,
  output logic [9:0]  out_hit_count,
  output logic [5:0]  out_time_diff_count,
  output logic [15:0] out_extended_timestamp,
  output logic [29:0] out_event_timestamp,
  output logic [31:0] out_broken_events,
  output logic [31:0] out_bin_count
);
  import almwu_pkg::*;

  localparam int BUS_W  = (BUSES > 1) ? $clog2(BUSES) : 1;
  localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int BIN_W  = $clog2(BINS);
  localparam int ADDR_W = BUS_W + CH_W + BIN_W;

  logic              acc;
  logic              hold;
  logic              mem_busy;
  item_t             item;
  item_t             res_item;
  logic [ADDR_W-1:0] addr;
  logic [31:0]       rd_data;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [31:0]       wr_data;

  assign in_stall = mem_busy || hold;
  assign acc      = in_valid && !in_stall;

  almwu_frame #(
    .BUSES    (BUSES),
    .CHANNELS (CHANNELS),
    .BINS     (BINS),
    .MAX_HITS (MAX_HITS),
    .MAX_TDIFF(MAX_TDIFF)
  ) u_frame (
    .clk          (clk),
    .rst_n        (rst_n),
    .acc          (acc),
    .op           (in_op),
    .word         (in_word),
    .query_bus    (in_query_bus),
    .query_channel(in_query_channel),
    .query_bin    (in_query_bin),
    .item         (item),
    .addr         (addr)
  );

  almwu_hist_mem #(
    .ADDR_W(ADDR_W)
  ) u_mem (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_en  (acc),
    .rd_addr(addr),
    .rd_data(rd_data),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .busy   (mem_busy)
  );

  almwu_bin_update #(
    .ADDR_W(ADDR_W)
  ) u_upd (
    .clk          (clk),
    .rst_n        (rst_n),
    .acc          (acc),
    .item_in      (item),
    .addr_in      (addr),
    .rd_data      (rd_data),
    .out_stall    (out_stall),
    .hold         (hold),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .out_valid    (out_valid),
    .out_item     (res_item),
    .out_bin_count(out_bin_count)
  );

  assign out_kind               = res_item.kind;
  assign out_bus                = res_item.bus;
  assign out_channel            = res_item.channel;
  assign out_value              = res_item.value;
  assign out_hit_count          = res_item.hit_count;
  assign out_time_diff_count    = res_item.time_diff_count;
  assign out_extended_timestamp = res_item.ext_stamp;
  assign out_event_timestamp    = res_item.event_stamp;
  assign out_broken_events      = res_item.broken;

endmodule

/* design/almwu_frame.sv */
`timescale 1ns / 1ps

module almwu_frame #(
  parameter int BUSES     = 16,
  parameter int CHANNELS  = 64,
  parameter int BINS      = 4096,
  parameter int MAX_HITS  = 1023,
  parameter int MAX_TDIFF = 47,
  localparam int BUS_W    = (BUSES > 1) ? $clog2(BUSES) : 1,
  localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1,
  localparam int BIN_W    = $clog2(BINS),
  localparam int ADDR_W   = BUS_W + CH_W + BIN_W
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                acc,
  input  logic                op,
  input  logic [31:0]         word,
  input  logic [3:0]          query_bus,
  input  logic [5:0]          query_channel,
  input  logic [11:0]         query_bin,
  output almwu_pkg::item_t    item,
  output logic [ADDR_W-1:0]   addr
);
  import almwu_pkg::*;

  localparam logic [1:0] PH_BLOCK  = 2'd0;
  localparam logic [1:0] PH_MODULE = 2'd1;
  localparam logic [1:0] PH_DATA   = 2'd2;
  localparam logic [1:0] PH_FILLER = 2'd3;

  localparam logic [3:0] TOP_HIT   = 4'b0001;
  localparam logic [3:0] TOP_EXT   = 4'b0010;
  localparam logic [3:0] TOP_TDIFF = 4'b0011;
  localparam logic [1:0] TOP_EVENT = 2'b11;

  localparam logic [4:0]  BUSES_L     = 5'(BUSES);
  localparam logic [12:0] CHANNELS_L  = 13'(CHANNELS);
  localparam logic [12:0] BINS_L      = 13'(BINS);
  localparam logic [9:0]  MAX_HITS_L  = 10'(MAX_HITS);
  localparam logic [5:0]  MAX_TDIFF_L = 6'(MAX_TDIFF);

  logic [1:0]  phase_r, phase_nxt;
  logic [12:0] words_left_r, words_left_nxt;
  logic [9:0]  hits_r, hits_nxt;
  logic [5:0]  tdiffs_r, tdiffs_nxt;
  logic [15:0] ext_r, ext_nxt;
  logic [29:0] evt_r, evt_nxt;
  logic [31:0] broken_r, broken_nxt;

  logic [3:0]  bus_sel;
  logic [11:0] chan_sel;
  logic [11:0] bin_sel;

  always_comb begin
    logic [12:0] len;
    logic [3:0]  top;
    logic        bus_ok;
    logic        chan_ok;
    len = word[12:0];
    top = word[31:28];
    bus_ok = {1'b0, word[27:24]} < BUSES_L;
    chan_ok = {1'b0, word[23:12]} < CHANNELS_L;

    phase_nxt      = phase_r;
    words_left_nxt = words_left_r;
    hits_nxt       = hits_r;
    tdiffs_nxt     = tdiffs_r;
    ext_nxt        = ext_r;
    evt_nxt        = evt_r;
    broken_nxt     = broken_r;

    item.kind    = KIND_IGNORED;
    item.bus     = '0;
    item.channel = '0;
    item.value   = '0;
    item.bin_upd = 1'b0;
    item.bin_rd  = 1'b0;
    bus_sel  = word[27:24];
    chan_sel = word[23:12];
    bin_sel  = word[11:0];

    priority if (op) begin
      item.kind    = KIND_BIN_READ;
      item.bus     = query_bus;
      item.channel = {6'd0, query_channel};
      item.value   = {4'd0, query_bin};
      item.bin_rd  = ({1'b0, query_bus} < BUSES_L) &&
                     ({7'd0, query_channel} < CHANNELS_L) &&
                     ({1'b0, query_bin} < BINS_L);
      bus_sel  = query_bus;
      chan_sel = {6'd0, query_channel};
      bin_sel  = query_bin;
    end else begin
      unique case (phase_r)
        PH_BLOCK: begin
          item.kind  = KIND_BLOCK_HDR;
          item.value = {3'd0, len};
          hits_nxt   = '0;
          tdiffs_nxt = '0;
          ext_nxt    = '0;
          evt_nxt    = '0;
          if (len > 13'd1) begin
            words_left_nxt = len - 13'd1;
            phase_nxt      = PH_MODULE;
          end else if (len == 13'd1) begin
            phase_nxt = PH_FILLER;
          end
        end
        PH_FILLER: begin
          item.kind  = KIND_FILLER;
          item.value = word[15:0];
          if (broken_r != '1) broken_nxt = broken_r + 32'd1;
          phase_nxt = PH_BLOCK;
        end
        PH_MODULE: begin
          item.kind  = KIND_MODULE_HDR;
          item.value = word[15:0];
          phase_nxt  = (words_left_r != '0) ? PH_DATA : PH_BLOCK;
        end
        PH_DATA: begin
          item.bus   = word[27:24];
          item.value = word[15:0];
          priority if (top == TOP_HIT) begin
            item.channel = word[23:12];
            item.value   = {4'd0, word[11:0]};
            if (chan_ok && bus_ok) begin
              item.kind    = KIND_HIT;
              item.bin_upd = {1'b0, word[11:0]} < BINS_L;
              hits_nxt     = (hits_r < MAX_HITS_L) ? hits_r + 10'd1 : MAX_HITS_L;
            end else begin
              item.kind = KIND_HIT_RANGE;
            end
            if (bus_ok) tdiffs_nxt = (tdiffs_r < MAX_TDIFF_L) ? tdiffs_r + 6'd1 : MAX_TDIFF_L;
          end else if (top == TOP_TDIFF) begin
            item.kind = KIND_TDIFF;
            if (bus_ok) tdiffs_nxt = (tdiffs_r < MAX_TDIFF_L) ? tdiffs_r + 6'd1 : MAX_TDIFF_L;
          end else if (top == TOP_EXT) begin
            item.kind = KIND_EXT_TS;
            ext_nxt   = word[15:0];
          end else if (top[3:2] == TOP_EVENT) begin
            item.kind = KIND_EVENT_TS;
            evt_nxt   = word[29:0];
          end else begin
            item.kind = KIND_IGNORED;
          end
          words_left_nxt = words_left_r - 13'd1;
          if (words_left_nxt == '0) phase_nxt = PH_BLOCK;
        end
        default: phase_nxt = PH_BLOCK;
      endcase
    end

    item.hit_count       = hits_nxt;
    item.time_diff_count = tdiffs_nxt;
    item.ext_stamp       = ext_nxt;
    item.event_stamp     = evt_nxt;
    item.broken          = broken_nxt;
  end

  assign addr = {bus_sel[BUS_W-1:0], chan_sel[CH_W-1:0], bin_sel[BIN_W-1:0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_BLOCK;
      words_left_r <= '0;
      hits_r       <= '0;
      tdiffs_r     <= '0;
      ext_r        <= '0;
      evt_r        <= '0;
      broken_r     <= '0;
    end else if (acc) begin
      phase_r      <= phase_nxt;
      words_left_r <= words_left_nxt;
      hits_r       <= hits_nxt;
      tdiffs_r     <= tdiffs_nxt;
      ext_r        <= ext_nxt;
      evt_r        <= evt_nxt;
      broken_r     <= broken_nxt;
    end
  end

endmodule

/* design/almwu_hist_mem.sv */
`timescale 1ns / 1ps

module almwu_hist_mem #(
  parameter int ADDR_W = 22
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [31:0]       rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [31:0]       wr_data,
  output logic              busy
);
  localparam int DEPTH = 1 << ADDR_W;

  logic [31:0]       hist_mem_r [DEPTH];
  logic [31:0]       rd_data_r;
  logic              clr_busy_r;
  logic [ADDR_W-1:0] clr_addr_r;

  // Sweep every bin to zero after reset, one per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == '1) clr_busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      hist_mem_r[clr_addr_r] <= '0;
    end else if (wr_en) begin
      hist_mem_r[wr_addr] <= wr_data;
    end
  end

  // Hold the read data until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) rd_data_r <= hist_mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;
  assign busy    = clr_busy_r;

endmodule

/* design/almwu_bin_update.sv */
`timescale 1ns / 1ps

module almwu_bin_update #(
  parameter int ADDR_W = 22
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              acc,
  input  almwu_pkg::item_t  item_in,
  input  logic [ADDR_W-1:0] addr_in,
  input  logic [31:0]       rd_data,
  input  logic              out_stall,
  output logic              hold,
  output logic              wr_en,
  output logic [ADDR_W-1:0] wr_addr,
  output logic [31:0]       wr_data,
  output logic              out_valid,
  output almwu_pkg::item_t  out_item,
  output logic [31:0]       out_bin_count
);
  import almwu_pkg::*;

  logic              s1_valid_r;
  item_t             s1_item_r;
  logic [ADDR_W-1:0] s1_addr_r;
  logic              fwd_hit_r;
  logic [31:0]       fwd_data_r;
  logic              out_valid_r;
  item_t             out_item_r;
  logic [31:0]       out_bin_r;

  logic        adv;
  logic        move;
  logic [31:0] cur;
  logic [31:0] inc;
  logic [31:0] bin_nxt;

  assign adv  = !out_valid_r || !out_stall;
  assign move = s1_valid_r && adv;
  assign hold = s1_valid_r && !adv;

  // A write landing on the edge of the read is not seen by the memory read.
  assign cur = fwd_hit_r ? fwd_data_r : rd_data;
  assign inc = (&cur) ? cur : cur + 32'd1;

  always_comb begin
    if (s1_item_r.bin_upd) begin
      bin_nxt = inc;
    end else if (s1_item_r.bin_rd) begin
      bin_nxt = cur;
    end else begin
      bin_nxt = '0;
    end
  end

  assign wr_en   = move && s1_item_r.bin_upd;
  assign wr_addr = s1_addr_r;
  assign wr_data = inc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (acc) begin
        s1_valid_r <= 1'b1;
      end else if (adv) begin
        s1_valid_r <= 1'b0;
      end
      if (adv) out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_item_r  <= item_in;
      s1_addr_r  <= addr_in;
      fwd_hit_r  <= wr_en && (wr_addr == addr_in);
      fwd_data_r <= wr_data;
    end
    if (move) begin
      out_item_r <= s1_item_r;
      out_bin_r  <= bin_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_item      = out_item_r;
  assign out_bin_count = out_bin_r;

endmodule

/* design/almwu_checker.sv */
`timescale 1ns / 1ps
`include "adc_listmode_word_unpacker_defines.svh"

module almwu_checker #(
  parameter int BINS      = 4096,
  parameter int MAX_TDIFF = 47
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [3:0]  out_kind,
  input logic [15:0] out_value,
  input logic [5:0]  out_time_diff_count,
  input logic [31:0] out_bin_count
);
  import almwu_pkg::*;

  // Reset empties the output and holds off input for the clearing sweep.
  `ALMWU_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_valid && in_stall, "output not quiet after reset")

  `ALMWU_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "stalled result dropped")

  // A counted hit has seen its own increment.
  `ALMWU_ASSERT(a_hit_nonzero, out_valid && out_kind == KIND_HIT && {4'd0, out_value} < 20'(BINS) |-> out_bin_count != 32'd0, "hit bin count is zero")

  `ALMWU_ASSERT(a_bin_zero, out_valid && out_kind != KIND_HIT && out_kind != KIND_BIN_READ |-> out_bin_count == 32'd0, "bin count on non-bin result")

  `ALMWU_ASSERT(a_tdiff_sat, out_valid |-> {26'd0, out_time_diff_count} <= 32'(MAX_TDIFF), "time difference count beyond limit")

endmodule

bind adc_listmode_word_unpacker almwu_checker #(
  .BINS     (BINS),
  .MAX_TDIFF(MAX_TDIFF)
) u_almwu_checker (.*);

/* tb/listmode_checker.sv */
`timescale 1ns / 1ps

module listmode_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_op,
  input  logic [31:0] in_word,
  input  logic [3:0]  in_query_bus,
  input  logic [5:0]  in_query_channel,
  input  logic [11:0] in_query_bin,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [3:0]  out_kind,
  input  logic [3:0]  out_bus,
  input  logic [11:0] out_channel,
  input  logic [15:0] out_value,
  input  logic [9:0]  out_hit_count,
  input  logic [5:0]  out_time_diff_count,
  input  logic [15:0] out_extended_timestamp,
  input  logic [29:0] out_event_timestamp,
  input  logic [31:0] out_broken_events,
  input  logic [31:0] out_bin_count,
  output int          fail_count,
  output int          pending
);
  import almwu_pkg::*;

  localparam int BUSES     = 16;
  localparam int CHANNELS  = 64;
  localparam int BINS      = 4096;
  localparam int MAX_HITS  = 1023;
  localparam int MAX_TDIFF = 47;

  typedef enum logic [1:0] {
    SEEK_BLOCK,
    SEEK_MODULE,
    IN_DATA,
    SEEK_FILLER
  } frame_e;

  typedef struct packed {
    logic [3:0]  kind;
    logic [3:0]  bus;
    logic [11:0] channel;
    logic [15:0] value;
    logic [9:0]  hits;
    logic [5:0]  tdiffs;
    logic [15:0] ext_stamp;
    logic [29:0] evt_stamp;
    logic [31:0] broken;
    logic [31:0] bin_count;
  } unpack_result_t;

  frame_e      frame;
  logic [12:0] words_left;
  logic [9:0]  hits;
  logic [5:0]  tdiffs;
  logic [15:0] ext_stamp;
  logic [29:0] evt_stamp;
  logic [31:0] broken;
  // sparse copy of the histogram; a missing key is a zero bin
  logic [31:0] hist [logic [21:0]];
  unpack_result_t expected_results[$];

  function automatic void bump_tdiffs();
    if (tdiffs < MAX_TDIFF) tdiffs++;
    else tdiffs = 6'(MAX_TDIFF);
  endfunction

  function automatic logic [31:0] bin_value(logic [21:0] key);
    return hist.exists(key) ? hist[key] : 32'd0;
  endfunction

  function automatic unpack_result_t predict_result(logic op, logic [31:0] w,
      logic [3:0] qb, logic [5:0] qc, logic [11:0] qv);
    unpack_result_t r;
    logic [3:0]  top;
    logic [12:0] len;
    logic [21:0] key;
    r = '0;
    r.kind = KIND_IGNORED;
    if (op) begin
      r.kind = KIND_BIN_READ;
      r.bus = qb;
      r.channel = {6'd0, qc};
      r.value = {4'd0, qv};
      if (qb < BUSES && qc < CHANNELS && qv < BINS) r.bin_count = bin_value({qb, qc, qv});
    end else begin
      case (frame)
        SEEK_BLOCK: begin
          len = w[12:0];
          r.kind = KIND_BLOCK_HDR;
          r.value = {3'd0, len};
          hits = '0;
          tdiffs = '0;
          ext_stamp = '0;
          evt_stamp = '0;
          if (len > 13'd1) begin
            words_left = len - 13'd1;
            frame = SEEK_MODULE;
          end else if (len == 13'd1) begin
            frame = SEEK_FILLER;
          end
        end
        SEEK_FILLER: begin
          r.kind = KIND_FILLER;
          r.value = w[15:0];
          if (broken != 32'hFFFF_FFFF) broken++;
          frame = SEEK_BLOCK;
        end
        SEEK_MODULE: begin
          r.kind = KIND_MODULE_HDR;
          r.value = w[15:0];
          frame = (words_left != 0) ? IN_DATA : SEEK_BLOCK;
        end
        default: begin
          top = w[31:28];
          r.bus = w[27:24];
          if (top == 4'h1) begin
            r.channel = w[23:12];
            r.value = {4'd0, w[11:0]};
            if (w[23:12] < CHANNELS && w[27:24] < BUSES) begin
              r.kind = KIND_HIT;
              if (w[11:0] < BINS) begin
                key = {w[27:24], w[17:12], w[11:0]};
                hist[key] = bin_value(key);
                if (hist[key] != 32'hFFFF_FFFF) hist[key]++;
                r.bin_count = hist[key];
              end
              if (hits < MAX_HITS) hits++;
              else hits = 10'(MAX_HITS);
            end else begin
              r.kind = KIND_HIT_RANGE;
            end
            if (w[27:24] < BUSES) bump_tdiffs();
          end else if (top == 4'h3) begin
            r.kind = KIND_TDIFF;
            r.value = w[15:0];
            if (w[27:24] < BUSES) bump_tdiffs();
          end else if (top == 4'h2) begin
            r.kind = KIND_EXT_TS;
            r.value = w[15:0];
            ext_stamp = w[15:0];
          end else if (top[3:2] == 2'b11) begin
            r.kind = KIND_EVENT_TS;
            r.value = w[15:0];
            evt_stamp = w[29:0];
          end else begin
            r.kind = KIND_IGNORED;
            r.value = w[15:0];
          end
          words_left = words_left - 13'd1;
          if (words_left == 0) frame = SEEK_BLOCK;
        end
      endcase
    end
    r.hits = hits;
    r.tdiffs = tdiffs;
    r.ext_stamp = ext_stamp;
    r.evt_stamp = evt_stamp;
    r.broken = broken;
    return r;
  endfunction

  function automatic string describe_result(unpack_result_t r);
    return $sformatf("kind %0d bus %0d ch %0d val %h hits %0d td %0d ext %h evt %h brk %0d bin %0d",
                     r.kind, r.bus, r.channel, r.value, r.hits, r.tdiffs, r.ext_stamp,
                     r.evt_stamp, r.broken, r.bin_count);
  endfunction

  always @(posedge clk) begin : monitor
    unpack_result_t got_r;
    unpack_result_t exp_r;
    if (!rst_n) begin
      frame = SEEK_BLOCK;
      words_left = '0;
      hits = '0;
      tdiffs = '0;
      ext_stamp = '0;
      evt_stamp = '0;
      broken = '0;
      hist.delete();
      expected_results.delete();
      fail_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        got_r = {out_kind, out_bus, out_channel, out_value, out_hit_count,
                 out_time_diff_count, out_extended_timestamp, out_event_timestamp,
                 out_broken_events, out_bin_count};
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected item: %s", describe_result(got_r));
        end else begin
          exp_r = expected_results.pop_front();
          if (got_r !== exp_r) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("mismatch expected: %s", describe_result(exp_r));
              $display("         actual:   %s", describe_result(got_r));
            end
          end
        end
      end
      if (in_valid && !in_stall)
        expected_results.push_back(predict_result(in_op, in_word, in_query_bus,
                                                  in_query_channel, in_query_bin));
    end
    pending = expected_results.size();
  end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import almwu_pkg::*;

  // the histogram sweep after reset alone is one long quiet stretch
  localparam int QUIET_LIMIT  = 20_000_000;
  localparam int HOLD_CYCLES  = 300;
  localparam int LONG_HITS    = 1025;
  localparam int RANDOM_ITEMS = 200;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_op;
  logic [31:0] in_word;
  logic [3:0]  in_query_bus;
  logic [5:0]  in_query_channel;
  logic [11:0] in_query_bin;
  logic        out_valid;
  logic        out_stall;
  logic [3:0]  out_kind;
  logic [3:0]  out_bus;
  logic [11:0] out_channel;
  logic [15:0] out_value;
  logic [9:0]  out_hit_count;
  logic [5:0]  out_time_diff_count;
  logic [15:0] out_extended_timestamp;
  logic [29:0] out_event_timestamp;
  logic [31:0] out_broken_events;
  logic [31:0] out_bin_count;

  int fail_count;
  int pending_results;
  int items_sent;
  int quiet_cycles = 0;
  bit in_idle_en;
  bit rx_idle_en;
  bit hold_req;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  adc_listmode_word_unpacker u_top (.*);

  listmode_checker u_checker (
    .clk, .rst_n, .in_valid, .in_stall, .in_op, .in_word, .in_query_bus,
    .in_query_channel, .in_query_bin, .out_valid, .out_stall, .out_kind, .out_bus,
    .out_channel, .out_value, .out_hit_count, .out_time_diff_count,
    .out_extended_timestamp, .out_event_timestamp, .out_broken_events, .out_bin_count,
    .fail_count, .pending(pending_results)
  );

  // result side: random stalls, plus one long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        out_stall <= rx_idle_en && ($urandom_range(99) < 33);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(input logic op, input logic [31:0] w, input logic [3:0] qb,
                           input logic [5:0] qc, input logic [11:0] qv);
    @(negedge clk);
    while (in_idle_en && $urandom_range(99) < 33) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_word <= w;
    in_query_bus <= qb;
    in_query_channel <= qc;
    in_query_bin <= qv;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_word(input logic [31:0] w);
    send_item(1'b0, w, 4'($urandom_range(15)), 6'($urandom_range(63)),
              12'($urandom_range(4095)));
  endtask

  // near: aim at the few bins that the biased hits keep bumping
  task automatic send_read(input bit near);
    if (near)
      send_item(1'b1, $urandom, 4'($urandom_range(1)), 6'($urandom_range(1)),
                12'($urandom_range(3)));
    else
      send_item(1'b1, $urandom, 4'($urandom_range(15)), 6'($urandom_range(63)),
                12'($urandom_range(4095)));
  endtask

  task automatic interleave_read();
    if ($urandom_range(9) == 0) send_read(1'($urandom_range(1)));
  endtask

  function automatic logic [31:0] random_data_word(int hit_pct, int tdiff_pct);
    int          pick;
    int          sub;
    logic [3:0]  bus;
    logic [11:0] chan;
    logic [11:0] amp;
    logic [31:0] w;
    pick = $urandom_range(99);
    w = $urandom;
    bus = $urandom_range(1) ? 4'($urandom_range(1)) : 4'($urandom_range(15));
    sub = $urandom_range(9);
    if (sub < 6) chan = 12'($urandom_range(1));
    else if (sub < 9) chan = 12'($urandom_range(63));
    else chan = 12'($urandom_range(4095, 64));
    amp = $urandom_range(1) ? 12'($urandom_range(3)) : 12'($urandom_range(4095));
    if (pick < hit_pct) begin
      w = {4'h1, bus, chan, amp};
    end else if (pick < hit_pct + tdiff_pct) begin
      w[31:28] = 4'h3;
    end else begin
      sub = $urandom_range(2);
      if (sub == 0) w[31:28] = 4'h2;
      else if (sub == 1) w[31:30] = 2'b11;
      else begin
        // 0 or 4..11 are not decoded
        sub = $urandom_range(8);
        w[31:28] = (sub == 0) ? 4'h0 : 4'(sub + 3);
      end
    end
    return w;
  endfunction

  task automatic send_block(input int n_data, input int hit_pct, input int tdiff_pct);
    logic [31:0] hdr;
    hdr = $urandom;
    hdr[12:0] = 13'(n_data + 1);
    send_word(hdr);
    interleave_read();
    send_word($urandom);
    for (int i = 0; i < n_data; i++) begin
      interleave_read();
      send_word(random_data_word(hit_pct, tdiff_pct));
    end
  endtask

  initial begin : stimulus
    int          random_start;
    int          sel;
    bit          held;
    logic [31:0] w;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_op = 1'b0;
    in_word = '0;
    in_query_bus = '0;
    in_query_channel = '0;
    in_query_bin = '0;
    in_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    hold_req = 1'b0;
    held = 1'b0;
    items_sent = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty and broken blocks, every data type, range edges
    send_item(1'b1, 32'hFFFF_FFFF, 4'hF, 6'd63, 12'hFFF);
    send_word(32'hFFFF_E000);
    send_word(32'h0000_0001);
    send_word(32'hFFFF_FFFF);
    send_word({19'd0, 13'd10});
    send_word(32'hFFFF_FFFF);
    send_word({4'h1, 4'hF, 12'd63, 12'hFFF});
    send_word({4'h1, 4'hF, 12'd63, 12'hFFF});
    send_word({4'h1, 4'h0, 12'd64, 12'h000});
    send_word({4'h1, 4'hF, 12'hFFF, 12'hFFF});
    send_word({4'h1, 28'h0});
    send_word({4'h3, 28'hFFF_FFFF});
    send_word({4'h2, 28'hFFF_FFFF});
    send_word(32'hFFFF_FFFF);
    send_word(32'h0ABC_DEF0);
    send_item(1'b1, 32'h0, 4'hF, 6'd63, 12'hFFF);
    send_item(1'b1, 32'h0, 4'h0, 6'd0, 12'h000);

    // one long event of in-range hits without idling: saturates the hit
    // and tdiff counts
    in_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    send_word({19'd0, 13'(LONG_HITS + 1)});
    send_word($urandom);
    for (int i = 0; i < LONG_HITS; i++)
      send_word({4'h1, 4'($urandom_range(15)), 12'($urandom_range(63)),
                 12'($urandom_range(3))});
    in_idle_en = 1'b1;
    rx_idle_en = 1'b1;

    random_start = items_sent;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      if (!held && items_sent - random_start > 50) begin
        hold_req = 1'b1;
        held = 1'b1;
      end
      sel = $urandom_range(99);
      if (sel < 8) begin
        w = $urandom;
        w[12:0] = '0;
        send_word(w);
      end else if (sel < 16) begin
        w = $urandom;
        w[12:0] = 13'd1;
        send_word(w);
        send_word($urandom);
      end else if (sel < 26) begin
        send_block($urandom_range(60, 48), 30, 60);
      end else if (sel < 30) begin
        repeat ($urandom_range(4, 1)) send_read(1'($urandom_range(1)));
      end else begin
        send_block($urandom_range(20, 1), 45, 15);
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

/* adc_listmode_word_unpacker.f */
+incdir+design
design/almwu_pkg.sv
design/almwu_frame.sv
design/almwu_hist_mem.sv
design/almwu_bin_update.sv
design/adc_listmode_word_unpacker.sv
design/almwu_checker.sv
tb/listmode_checker.sv
tb/tb_top.sv
